// File: hdl/pidff_pkg.sv
package pidff_pkg;

	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int VAL_W   = 32;
	localparam int LIMIT_W = 31;

	typedef enum logic [2:0] {
		REG_KP    = 3'd0,
		REG_KI    = 3'd1,
		REG_KD    = 3'd2,
		REG_LIMIT = 3'd3,
		REG_FF    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]   kp;
		logic signed [VAL_W-1:0]   ki;
		logic signed [VAL_W-1:0]   kd;
		logic        [LIMIT_W-1:0] limit;
		logic signed [VAL_W-1:0]   ff;
	} cfg_t;

endpackage

// File: hdl/pid_with_feedforward_core.sv
// PID controller with speed feedforward and a symmetric integral clamp, signed fixed point
// with FRAC_BITS fractional bits. Load the gains over the register port (0x00 kp, 0x04 ki,
// 0x08 kd, 0x0C integral limit, 0x10 feedforward gain) while no transaction is in flight.
// Each input transaction updates the integral (saturated, then clamped to +/- limit when
// the limit is nonzero) and the previous error in the cycle it is accepted, and presents one
// drive value on the output after the stage registers; a new transaction is taken every
// cycle, and the three stages (state update, four products, floor shift and saturating sum)
// stall together only while the output register holds a result that is not taken.
module pid_with_feedforward_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pidff_pkg::ADDR_W-1:0]   paddr,
	input  logic [pidff_pkg::DATA_W-1:0]   pwdata,
	output logic [pidff_pkg::DATA_W-1:0]   prdata,
	output logic                           pready,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [63:0]                    s_axis_tdata,  // position_error, target_speed
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [31:0]                    m_axis_tdata   // drive_value
);
	import pidff_pkg::*;

	localparam int PW = 2 * VAL_W + 2;

	cfg_t cfg;

	logic                    adv, s_acc;
	logic signed [VAL_W-1:0] err_in, spd_in;
	logic signed [VAL_W:0]   isum, isat, iclamp, lim33, deriv_in;
	logic signed [VAL_W-1:0] integral_q, last_q;

	logic                    vld_s1, vld_s2, vld_s3;
	logic signed [VAL_W-1:0] err_s1, spd_s1, integ_s1;
	logic signed [VAL_W:0]   deriv_s1;
	logic signed [PW-1:0]    pff_s2, pkp_s2, pki_s2, pkd_s2;
	logic signed [PW-1:0]    sum;
	logic signed [VAL_W-1:0] drive_s3;

	pidff_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	assign pready = 1'b1;

	assign adv           = !vld_s3 || m_axis_tready;
	assign s_axis_tready = adv;
	assign s_acc         = s_axis_tvalid && adv;

	assign err_in = s_axis_tdata[31:0];
	assign spd_in = s_axis_tdata[63:32];

	always_comb begin
		isum  = {integral_q[VAL_W-1], integral_q} + {err_in[VAL_W-1], err_in};
		if (isum[VAL_W] != isum[VAL_W-1])
			isat = isum[VAL_W] ? {2'b11, {(VAL_W-1){1'b0}}} : {2'b00, {(VAL_W-1){1'b1}}};
		else
			isat = isum;
		lim33  = {2'b00, cfg.limit};
		iclamp = isat;
		if (cfg.limit != '0) begin
			if (isat > lim33)
				iclamp = lim33;
			else if (isat < -lim33)
				iclamp = -lim33;
		end
		deriv_in = {err_in[VAL_W-1], err_in} - {last_q[VAL_W-1], last_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
			last_q     <= '0;
		end else if (s_acc) begin
			integral_q <= iclamp[VAL_W-1:0];
			last_q     <= err_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_acc;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			err_s1   <= err_in;
			spd_s1   <= spd_in;
			integ_s1 <= iclamp[VAL_W-1:0];
			deriv_s1 <= deriv_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pff_s2 <= PW'(spd_s1 * cfg.ff);
			pkp_s2 <= PW'(err_s1 * cfg.kp);
			pki_s2 <= PW'(integ_s1 * cfg.ki);
			pkd_s2 <= PW'(deriv_s1 * cfg.kd);
		end
	end

	assign sum = (pff_s2 >>> FRAC_BITS) + (pkp_s2 >>> FRAC_BITS)
	           + (pki_s2 >>> FRAC_BITS) + (pkd_s2 >>> FRAC_BITS);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (sum > PW'(64'sh7FFF_FFFF))
				drive_s3 <= {1'b0, {(VAL_W-1){1'b1}}};
			else if (sum < -PW'(64'sh8000_0000))
				drive_s3 <= {1'b1, {(VAL_W-1){1'b0}}};
			else
				drive_s3 <= sum[VAL_W-1:0];
		end
	end

	assign m_axis_tvalid = vld_s3;
	assign m_axis_tdata  = drive_s3;

	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (vld_s3 && !m_axis_tready))
		else $error("input stalled without output backpressure");

	a_last_error: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> (last_q == $past(err_in)))
		else $error("previous error not captured");

	a_integral_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && cfg.limit != '0) |=>
		(($signed({integral_q[VAL_W-1], integral_q}) <= $signed({2'b00, $past(cfg.limit)}))
		&& ($signed({integral_q[VAL_W-1], integral_q}) >= -$signed({2'b00, $past(cfg.limit)}))))
		else $error("integral outside clamp");

	a_pipe_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && adv) |=> vld_s3)
		else $error("result lost between stages");

endmodule

// File: hdl/pidff_regs.sv
module pidff_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pidff_pkg::ADDR_W-1:0]   paddr,
	input  logic [pidff_pkg::DATA_W-1:0]   pwdata,
	output logic [pidff_pkg::DATA_W-1:0]   prdata,
	output pidff_pkg::cfg_t                cfg
);
	import pidff_pkg::*;

	logic     wr_en;
	reg_idx_t idx;

	assign wr_en = psel && penable && pwrite;
	assign idx   = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_KP:    cfg.kp    <= pwdata;
				REG_KI:    cfg.ki    <= pwdata;
				REG_KD:    cfg.kd    <= pwdata;
				REG_LIMIT: cfg.limit <= pwdata[LIMIT_W-1:0];
				REG_FF:    cfg.ff    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_KP:    prdata = cfg.kp;
			REG_KI:    prdata = cfg.ki;
			REG_KD:    prdata = cfg.kd;
			REG_LIMIT: prdata = {{(DATA_W-LIMIT_W){1'b0}}, cfg.limit};
			REG_FF:    prdata = cfg.ff;
			default:   prdata = '0;
		endcase
	end

endmodule

// File: bench/pid_with_feedforward_core_test.sv
module pid_with_feedforward_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pidff_pkg::*;

	localparam int     HALF_PERIOD   = 4;
	localparam int     RESET_CYCLES  = 6;
	localparam int     FRAC          = 16;
	localparam int     SETTLE_CYCLES = 8;
	localparam int     IDLE_LIMIT    = 4000;
	localparam int     RANDOM_PHASES = 8;
	localparam int     PHASE_TICKS   = 112;
	localparam longint SAT_HI        = 64'sd2147483647;
	localparam longint SAT_LO        = -64'sd2147483647 - 64'sd1;

	localparam logic [2:0]  SPARE_IDX_LO = 3'd5;
	localparam logic [2:0]  SPARE_IDX_HI = 3'd7;
	localparam logic [31:0] WORD_MAX     = 32'h7FFF_FFFF;
	localparam logic [31:0] WORD_MIN     = 32'h8000_0000;
	localparam logic [31:0] WORD_ONES    = 32'hFFFF_FFFF;
	localparam logic [31:0] Q_ONE        = 32'h0001_0000;

	typedef struct packed {
		logic signed [31:0] speed;
		logic signed [31:0] err;
	} tick_t;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                psel          = 1'b0;
	logic                penable       = 1'b0;
	logic                pwrite        = 1'b0;
	logic [ADDR_W-1:0]   paddr         = '0;
	logic [DATA_W-1:0]   pwdata        = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [63:0]         s_axis_tdata  = '0;  // position_error, target_speed
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [31:0]         m_axis_tdata;        // drive_value

	tick_t       tick_queue[$];
	logic [31:0] drive_q[$];

	logic signed [31:0]  gain_kp = '0;
	logic signed [31:0]  gain_ki = '0;
	logic signed [31:0]  gain_kd = '0;
	logic signed [31:0]  gain_ff = '0;
	logic [LIMIT_W-1:0]  gain_limit = '0;
	logic signed [31:0]  integral_acc = '0;
	logic signed [31:0]  prev_error = '0;

	int mismatches = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_mode = 0;
	int mode_left = 0;

	pid_with_feedforward_core #(
		.FRAC_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic longint clip32(longint v);
		if (v > SAT_HI) return SAT_HI;
		if (v < SAT_LO) return SAT_LO;
		return v;
	endfunction

	// advance the controller state by one tick and return the drive it produces
	function automatic logic [31:0] predict_drive(logic signed [31:0] err,
			logic signed [31:0] spd);
		longint acc;
		longint lim;
		longint diff;
		longint total;
		acc = clip32(longint'(integral_acc) + longint'(err));
		lim = longint'(gain_limit);
		if (lim != 0) begin
			if (acc > lim)
				acc = lim;
			else if (acc < -lim)
				acc = -lim;
		end
		diff = longint'(err) - longint'(prev_error);
		total = ((longint'(spd) * longint'(gain_ff)) >>> FRAC)
			+ ((longint'(err) * longint'(gain_kp)) >>> FRAC)
			+ ((acc * longint'(gain_ki)) >>> FRAC)
			+ ((diff * longint'(gain_kd)) >>> FRAC);
		integral_acc = acc[31:0];
		prev_error = err;
		total = clip32(total);
		return total[31:0];
	endfunction

	function automatic logic [31:0] pick_word(int span_bits);
		int mag;
		mag = 1 << span_bits;
		case ($urandom_range(0, 9))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return '0;
			3: return WORD_ONES;
			4, 5: return $urandom;
			default: return 32'($urandom_range(0, 2 * mag)) - 32'(mag);
		endcase
	endfunction

	function automatic logic [31:0] pick_limit();
		case ($urandom_range(0, 7))
			0, 1: return '0;
			2: return WORD_MAX;
			3, 4: return $urandom;
			default: return 32'($urandom_range(1, 1 << 20));
		endcase
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_KP: gain_kp = val;
			REG_KI: gain_ki = val;
			REG_KD: gain_kd = val;
			REG_LIMIT: gain_limit = val[LIMIT_W-1:0];
			REG_FF: gain_ff = val;
			default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_gains(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
			logic [31:0] lim, logic [31:0] ff);
		write_reg(REG_KP, kp);
		write_reg(REG_KI, ki);
		write_reg(REG_KD, kd);
		write_reg(REG_LIMIT, lim);
		write_reg(REG_FF, ff);
		@(negedge clk);
	endtask

	task automatic add_tick(logic [31:0] err, logic [31:0] spd);
		tick_t t;
		t.err = err;
		t.speed = spd;
		tick_queue.push_back(t);
	endtask

	// hold off until every pending tick is sent and every drive value has come back
	task automatic wait_drained();
		while (tick_queue.size() != 0 || s_axis_tvalid || drive_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && (!s_axis_tvalid || s_axis_tready)) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (tick_queue.size() != 0) begin
				s_axis_tdata <= tick_queue.pop_front();
				s_axis_tvalid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= ($urandom_range(0, 7) == 0) ?
						$urandom_range(100, 300) : $urandom_range(1, 12);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(16, 64);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				2: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		tick_t       t;
		logic [31:0] want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (drive_q.size() == 0) begin
					$error("drive_value unexpected: expected none, actual %0d",
						$signed(m_axis_tdata));
					mismatches++;
				end else begin
					want = drive_q.pop_front();
					if (m_axis_tdata !== want) begin
						$error("drive_value mismatch: expected %0d, actual %0d",
							$signed(want), $signed(m_axis_tdata));
						mismatches++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				t = s_axis_tdata;
				drive_q.push_back(predict_drive(t.err, t.speed));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (psel && penable && pwrite && pready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// unit kp and ff gains, ki one half, kd one quarter, no clamp, integral driven into saturation both ways
		write_gains(Q_ONE, Q_ONE >> 1, Q_ONE >> 2, '0, Q_ONE);
		write_reg(SPARE_IDX_LO, WORD_ONES);
		write_reg(SPARE_IDX_HI, WORD_MIN);
		@(negedge clk);
		add_tick('0, '0);
		add_tick(32'd1, WORD_ONES);
		add_tick(WORD_ONES, 32'd1);
		add_tick(WORD_MAX, WORD_MAX);
		add_tick(WORD_MAX, WORD_MIN);
		add_tick(WORD_MAX, '0);
		add_tick(WORD_MIN, '0);
		add_tick(WORD_MIN, '0);
		add_tick(WORD_MIN, WORD_MIN);
		add_tick(WORD_MIN, WORD_MIN);
		wait_drained();

		// extreme gains, tight clamp with the unused top bit set
		write_gains(WORD_MIN, WORD_MAX, WORD_MIN, 32'h8000_0100, WORD_MAX);
		add_tick(32'h0000_1000, '0);
		add_tick(32'h0000_1000, WORD_ONES);
		add_tick(32'hFFFF_B000, '0);
		add_tick(WORD_MAX, WORD_MAX);
		add_tick(WORD_MIN, WORD_MIN);
		add_tick(WORD_ONES, WORD_ONES);
		add_tick(32'h0000_FFFF, 32'd1);
		wait_drained();

		// widest clamp, small gains, most of them negative, to exercise floor rounding
		write_gains(32'hFFFF_FFFD, 32'd1, 32'hFFFF_0000, WORD_MAX, WORD_ONES);
		add_tick(WORD_MAX, 32'hFFFF_FFFD);
		add_tick(WORD_MAX, 32'd5);
		add_tick(WORD_MIN, Q_ONE);
		add_tick(32'hFFFF_FFF9, 32'd7);
		add_tick(32'd3, WORD_MIN);
		wait_drained();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_gains(pick_word(17), pick_word(17), pick_word(17), pick_limit(),
				pick_word(17));
			for (int i = 0; i < PHASE_TICKS; i++)
				add_tick(pick_word(18), pick_word(18));
			wait_drained();
		end

		if (drive_q.size() != 0) begin
			$error("drive_value missing: expected %0d more, actual 0", drive_q.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
